// ===== design/ljfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ljfa_pkg
// shared types and constants of the lennard-jones force accumulator
// ----------------------------------------------------------------------------
package ljfa_pkg;

  localparam int ID_BITS_DEF = 20;
  localparam int DISP_W      = 32;
  localparam int FORCE_W     = 48;
  localparam int COEF_W      = 32;
  localparam int OPND_W      = 64;
  localparam int PROD_W      = 128;
  localparam int SQ_W        = 40;
  localparam int QUO_W       = 49;
  localparam int ADDR_W      = 6;

  localparam logic [63:0] CAP = 64'h3FFF_FFFF_FFFF_FFFF;

  // register indexes
  localparam logic [2:0] REG_COEF_ATTRACT = 3'd0;
  localparam logic [2:0] REG_COEF_REPULSE = 3'd1;
  localparam logic [2:0] REG_BIAS_X       = 3'd2;
  localparam logic [2:0] REG_BIAS_Y       = 3'd3;
  localparam logic [2:0] REG_BIAS_Z       = 3'd4;

  // sequencer steps
  localparam logic [3:0] STEP_SQ0 = 4'd0;
  localparam logic [3:0] STEP_SQ1 = 4'd1;
  localparam logic [3:0] STEP_SQ2 = 4'd2;
  localparam logic [3:0] STEP_U2  = 4'd3;
  localparam logic [3:0] STEP_U4  = 4'd4;
  localparam logic [3:0] STEP_U3  = 4'd5;
  localparam logic [3:0] STEP_U7  = 4'd6;
  localparam logic [3:0] STEP_TA  = 4'd7;
  localparam logic [3:0] STEP_TB  = 4'd8;
  localparam logic [3:0] STEP_F0  = 4'd9;
  localparam logic [3:0] STEP_F1  = 4'd10;
  localparam logic [3:0] STEP_F2  = 4'd11;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } mul_req_t;

endpackage

// ===== design/ljfa_if.sv =====
// ----------------------------------------------------------------------------
// ljfa_pair_if / ljfa_force_if
// valid/ready channels for pair items and force results
// ----------------------------------------------------------------------------
interface ljfa_pair_if #(
  parameter int ID_BITS = ljfa_pkg::ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  logic [ID_BITS-1:0] own_id;
  logic [ID_BITS-1:0] partner_id;
  logic               first_pair;
  logic               last_pair;

  modport source (output valid, disp_x, disp_y, disp_z, own_id, partner_id,
                  first_pair, last_pair, input ready);
  modport sink (input valid, disp_x, disp_y, disp_z, own_id, partner_id,
                first_pair, last_pair, output ready);
endinterface

interface ljfa_force_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic               saturated;

  modport source (output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

// ===== design/ljfa_mul.sv =====
// ----------------------------------------------------------------------------
// ljfa_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module ljfa_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  ljfa_pkg::mul_req_t                  req,
  output logic                                done,
  output logic [ljfa_pkg::PROD_W-1:0]         prod
);
  logic [ljfa_pkg::OPND_W-1:0] a;
  logic [ljfa_pkg::OPND_W-1:0] b;
  logic [63:0]                 part;
  logic [1:0]                  part_sh;
  logic [2:0]                  cnt;
  logic                        busy;
  logic [31:0]                 pa;
  logic [31:0]                 pb;
  logic [1:0]                  sh_now;
  logic [ljfa_pkg::PROD_W-1:0] part_ext;

  always_comb begin
    case (cnt)
      3'd0: begin pa = a[31:0];  pb = b[31:0];  sh_now = 2'd0; end
      3'd1: begin pa = a[31:0];  pb = b[63:32]; sh_now = 2'd1; end
      3'd2: begin pa = a[63:32]; pb = b[31:0];  sh_now = 2'd1; end
      default: begin pa = a[63:32]; pb = b[63:32]; sh_now = 2'd2; end
    endcase
  end

  always_comb begin
    case (part_sh)
      2'd0:    part_ext = {64'd0, part};
      2'd1:    part_ext = {32'd0, part, 32'd0};
      default: part_ext = {part, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= !req.start && busy && (cnt == 3'd4);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        prod <= '0;
        a    <= req.a;
        b    <= req.b;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          part    <= pa * pb;
          part_sh <= sh_now;
        end
        if (cnt != 3'd0) prod <= prod + part_ext;
        if (cnt == 3'd4) busy <= 1'b0;
        cnt <= cnt + 3'd1;
      end
    end
  end
endmodule

// ===== design/ljfa_div.sv =====
// ----------------------------------------------------------------------------
// ljfa_div
// restoring divider, 2^48 / divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ljfa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ljfa_pkg::SQ_W-1:0]    divisor,
  output logic                         done,
  output logic [ljfa_pkg::QUO_W-1:0]   quo
);
  logic [ljfa_pkg::SQ_W-1:0] d;
  logic [ljfa_pkg::SQ_W-1:0] rem;
  logic [5:0]                cnt;
  logic                      busy;
  logic [ljfa_pkg::SQ_W:0]   trial;
  logic                      fits;

  assign trial = {rem, (cnt == 6'(ljfa_pkg::QUO_W - 1))};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 6'd0);
      if (start) begin
        busy <= 1'b1;
        d    <= divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= 6'(ljfa_pkg::QUO_W - 1);
      end else if (busy) begin
        rem <= fits ? ljfa_pkg::SQ_W'(trial - {1'b0, d}) : ljfa_pkg::SQ_W'(trial);
        quo <= {quo[ljfa_pkg::QUO_W-2:0], fits};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end
endmodule

// ===== design/lennard_jones_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_force_accumulator
// sums lennard-jones pair forces on one particle, fixed point
// ----------------------------------------------------------------------------
// One pair is taken at a time; ready stays low while it is worked. A pair with
// equal ids skips the arithmetic and goes straight to the done state. Any other
// pair runs twelve 64x64 products on one shared 32x32 multiplier and a 49-step
// divider; the multiplier forms four partial products per product, and the
// divider yields one quotient bit per cycle. A pair whose squared distance,
// shifted down by 24 bits, is zero stops after the squared distance. A result
// on a last pair sits in an output register, and the next pair is taken while
// it waits; an earlier result still waiting holds the block until it leaves.
module lennard_jones_force_accumulator #(
  parameter int ID_BITS = ljfa_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  ljfa_pair_if.sink                   pair_in,
  ljfa_force_if.source                force_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ljfa_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DIVW  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [31:0]        coef_attract;
  logic [31:0]        coef_repulse;
  logic signed [47:0] bias [3];
  logic signed [47:0] acc [3];
  logic               sat_seen;

  logic [31:0] mag [3];
  logic        neg [3];
  logic        last_r;
  logic [3:0]  step;
  logic [63:0] s;
  logic [48:0] u;
  logic [63:0] u2, u3, u4, u7, ta, tb;

  ljfa_pkg::mul_req_t mreq;
  logic                mdone;
  logic [127:0]        prod;
  logic                dstart;
  logic                ddone;
  logic [48:0]         quo;
  logic                out_load;

  // configuration
  logic [2:0] reg_sel;
  assign reg_sel = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_attract <= 32'd1572864;
      coef_repulse <= 32'd3145728;
      bias[0]      <= '0;
      bias[1]      <= '0;
      bias[2]      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ljfa_pkg::REG_COEF_ATTRACT: coef_attract <= pwdata[31:0];
        ljfa_pkg::REG_COEF_REPULSE: coef_repulse <= pwdata[31:0];
        ljfa_pkg::REG_BIAS_X:       bias[0]      <= pwdata[47:0];
        ljfa_pkg::REG_BIAS_Y:       bias[1]      <= pwdata[47:0];
        ljfa_pkg::REG_BIAS_Z:       bias[2]      <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ljfa_pkg::REG_COEF_ATTRACT: prdata = {32'd0, coef_attract};
      ljfa_pkg::REG_COEF_REPULSE: prdata = {32'd0, coef_repulse};
      ljfa_pkg::REG_BIAS_X:       prdata = 64'(bias[0]);
      ljfa_pkg::REG_BIAS_Y:       prdata = 64'(bias[1]);
      ljfa_pkg::REG_BIAS_Z:       prdata = 64'(bias[2]);
      default:                    prdata = '0;
    endcase
  end

  // operand select and result shaping
  logic [63:0]  s_next;
  logic [127:0] shifted;
  logic         capped;
  logic [63:0]  res;
  logic         cneg;
  logic [61:0]  cmag;
  logic [1:0]   fk;
  logic [48:0]  fm;
  logic         fm_big;
  logic signed [48:0] f;
  logic signed [48:0] f_cl;
  logic         f_sat;
  logic signed [49:0] sum;
  logic signed [47:0] sum_cl;
  logic         sum_sat;

  assign s_next  = s + prod[63:0];
  assign shifted = (step == ljfa_pkg::STEP_TA || step == ljfa_pkg::STEP_TB)
                   ? (prod >> 16) : (prod >> 24);
  assign capped  = |shifted[127:62];
  assign res     = capped ? ljfa_pkg::CAP : shifted[63:0];
  assign cneg    = tb > ta;
  assign cmag    = cneg ? 62'(tb - ta) : 62'(ta - tb);
  assign fk      = 2'(step - ljfa_pkg::STEP_F0);
  assign fm_big  = res > 64'h8000_0000_0000;
  assign fm      = fm_big ? 49'h0_8000_0000_0000 : res[48:0];
  assign f       = (neg[fk] != cneg) ? -$signed(fm) : $signed(fm);
  assign f_sat   = f > 49'sh0_7FFF_FFFF_FFFF;
  assign f_cl    = f_sat ? 49'sh0_7FFF_FFFF_FFFF : f;
  assign sum     = 50'(acc[fk]) + 50'(f_cl);

  always_comb begin
    sum_sat = 1'b0;
    sum_cl  = sum[47:0];
    if (sum > 50'sh0_7FFF_FFFF_FFFF) begin
      sum_sat = 1'b1;
      sum_cl  = 48'sh7FFF_FFFF_FFFF;
    end else if (sum < -50'sh0_8000_0000_0000) begin
      sum_sat = 1'b1;
      sum_cl  = 48'sh8000_0000_0000;
    end
  end

  always_comb begin
    mreq.start = (state == S_ISSUE);
    case (step)
      ljfa_pkg::STEP_SQ0: begin mreq.a = 64'(mag[0]); mreq.b = 64'(mag[0]); end
      ljfa_pkg::STEP_SQ1: begin mreq.a = 64'(mag[1]); mreq.b = 64'(mag[1]); end
      ljfa_pkg::STEP_SQ2: begin mreq.a = 64'(mag[2]); mreq.b = 64'(mag[2]); end
      ljfa_pkg::STEP_U2:  begin mreq.a = 64'(u);      mreq.b = 64'(u);      end
      ljfa_pkg::STEP_U4:  begin mreq.a = u2;          mreq.b = u2;          end
      ljfa_pkg::STEP_U3:  begin mreq.a = u2;          mreq.b = 64'(u);      end
      ljfa_pkg::STEP_U7:  begin mreq.a = u4;          mreq.b = u3;          end
      ljfa_pkg::STEP_TA:  begin mreq.a = 64'(coef_attract); mreq.b = u4;    end
      ljfa_pkg::STEP_TB:  begin mreq.a = 64'(coef_repulse); mreq.b = u7;    end
      default:            begin mreq.a = 64'(mag[fk]); mreq.b = 64'(cmag);  end
    endcase
  end

  ljfa_mul u_mul (.clk, .rst, .req(mreq), .done(mdone), .prod);

  ljfa_div u_div (.clk, .rst, .start(dstart), .divisor(s_next[63:24]),
                  .done(ddone), .quo);

  assign dstart        = (state == S_WAIT) && mdone && (step == ljfa_pkg::STEP_SQ2)
                         && (s_next[63:24] != '0);
  assign pair_in.ready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && last_r
                         && (!force_out.valid || force_out.ready);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_out.valid <= 1'b0;
    end else if (out_load) begin
      force_out.valid     <= 1'b1;
      force_out.force_x   <= acc[0];
      force_out.force_y   <= acc[1];
      force_out.force_z   <= acc[2];
      force_out.saturated <= sat_seen;
    end else if (force_out.ready) begin
      force_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      acc[0]          <= '0;
      acc[1]          <= '0;
      acc[2]          <= '0;
      sat_seen        <= 1'b0;
      step            <= ljfa_pkg::STEP_SQ0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pair_in.valid) begin
            if (pair_in.first_pair) begin
              acc[0]   <= bias[0];
              acc[1]   <= bias[1];
              acc[2]   <= bias[2];
              sat_seen <= 1'b0;
            end
            neg[0] <= pair_in.disp_x[31];
            neg[1] <= pair_in.disp_y[31];
            neg[2] <= pair_in.disp_z[31];
            mag[0] <= pair_in.disp_x[31] ? -pair_in.disp_x : pair_in.disp_x;
            mag[1] <= pair_in.disp_y[31] ? -pair_in.disp_y : pair_in.disp_y;
            mag[2] <= pair_in.disp_z[31] ? -pair_in.disp_z : pair_in.disp_z;
            last_r <= pair_in.last_pair;
            s      <= '0;
            step   <= ljfa_pkg::STEP_SQ0;
            state  <= (pair_in.own_id[ID_BITS-1:0] == pair_in.partner_id[ID_BITS-1:0])
                      ? S_DONE : S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mdone) begin
            case (step)
              ljfa_pkg::STEP_SQ0, ljfa_pkg::STEP_SQ1: begin
                s     <= s_next;
                step  <= step + 4'd1;
                state <= S_ISSUE;
              end
              ljfa_pkg::STEP_SQ2: begin
                s <= s_next;
                if (s_next[63:24] == '0) begin
                  sat_seen <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  state <= S_DIVW;
                end
              end
              ljfa_pkg::STEP_U2, ljfa_pkg::STEP_U4, ljfa_pkg::STEP_U3,
              ljfa_pkg::STEP_U7, ljfa_pkg::STEP_TA, ljfa_pkg::STEP_TB: begin
                case (step)
                  ljfa_pkg::STEP_U2: u2 <= res;
                  ljfa_pkg::STEP_U4: u4 <= res;
                  ljfa_pkg::STEP_U3: u3 <= res;
                  ljfa_pkg::STEP_U7: u7 <= res;
                  ljfa_pkg::STEP_TA: ta <= res;
                  default:           tb <= res;
                endcase
                if (capped) sat_seen <= 1'b1;
                step  <= step + 4'd1;
                state <= S_ISSUE;
              end
              default: begin
                acc[fk] <= sum_cl;
                if (capped || fm_big || f_sat || sum_sat) sat_seen <= 1'b1;
                if (step == ljfa_pkg::STEP_F2) begin
                  state <= S_DONE;
                end else begin
                  step  <= step + 4'd1;
                  state <= S_ISSUE;
                end
              end
            endcase
          end
        end
        S_DIVW: begin
          if (ddone) begin
            u     <= quo;
            step  <= ljfa_pkg::STEP_U2;
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!last_r || out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (pair_in.valid && pair_in.ready) |=> state != S_IDLE)
    else $error("pair transfer did not start work");

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mdone |-> state == S_WAIT)
    else $error("multiplier finished outside wait");

  a_div_done_in_divw: assert property (@(posedge clk) disable iff (rst)
    ddone |-> state == S_DIVW)
    else $error("divider finished outside wait");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(force_out.valid) |-> $past(state == S_DONE))
    else $error("result raised outside done");
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lennard-jones force accumulator: pair sequences
// are driven over the pair channel under several register settings, and every
// summed force is compared against an in-bench fixed-point force model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int  IDW        = ljfa_pkg::ID_BITS_DEF;
  localparam int  CYCLE_CAP  = 1000000;
  localparam int  DRAIN_WAIT = 200;
  localparam longint MAX48   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48   = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [IDW-1:0]     own;
    logic [IDW-1:0]     partner;
    logic               first;
    logic               last;
  } pair_t;

  typedef struct packed {
    logic [47:0] fx;
    logic [47:0] fy;
    logic [47:0] fz;
    logic        sat;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ljfa_pkg::ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  ljfa_pair_if #(.ID_BITS(IDW)) pair ();
  ljfa_force_if                 res ();

  lennard_jones_force_accumulator #(.ID_BITS(IDW)) dut (
    .clk(clk), .rst(rst), .pair_in(pair), .force_out(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  pair_t  cur_pair;
  int     errors = 0;
  int     accepted = 0;
  int     cycles = 0;

  // model copy of registers and state
  logic [31:0] coef_a, coef_b;
  longint      bias[3];
  longint      acc[3];
  logic        sat_seen;

  function automatic logic [63:0] capped_mul(input logic [63:0] a, input logic [63:0] b,
                                             input int sh, inout logic sat);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    if (p > {64'b0, ljfa_pkg::CAP}) begin
      sat = 1'b1;
      return ljfa_pkg::CAP;
    end
    return p[63:0];
  endfunction

  function automatic longint clamp48(input longint v, inout logic sat);
    if (v > MAX48) begin
      sat = 1'b1;
      return MAX48;
    end
    if (v < MIN48) begin
      sat = 1'b1;
      return MIN48;
    end
    return v;
  endfunction

  function automatic void accumulate_pair(input pair_t p);
    logic [63:0] mag[3];
    logic        neg[3];
    logic [31:0] raw[3];
    logic [63:0] s, sq, u, u2, u4, u3, u7, ta, tb, cmag, fm;
    logic        cneg, sat;
    longint      f;
    force_t      r;
    if (p.first) begin
      for (int k = 0; k < 3; k++) acc[k] = bias[k];
      sat_seen = 1'b0;
    end
    raw[0] = p.dx;
    raw[1] = p.dy;
    raw[2] = p.dz;
    for (int k = 0; k < 3; k++) begin
      neg[k] = raw[k][31];
      mag[k] = neg[k] ? (64'h1_0000_0000 - {32'b0, raw[k]}) : {32'b0, raw[k]};
    end
    if (p.own != p.partner) begin
      s  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      sq = s >> 24;
      if (sq == 0) begin
        sat_seen = 1'b1;
      end else begin
        sat  = 1'b0;
        u    = (64'd1 << 48) / sq;
        u2   = capped_mul(u, u, 24, sat);
        u4   = capped_mul(u2, u2, 24, sat);
        u3   = capped_mul(u2, u, 24, sat);
        u7   = capped_mul(u4, u3, 24, sat);
        ta   = capped_mul({32'b0, coef_a}, u4, 16, sat);
        tb   = capped_mul({32'b0, coef_b}, u7, 16, sat);
        cneg = tb > ta;
        cmag = cneg ? tb - ta : ta - tb;
        for (int k = 0; k < 3; k++) begin
          fm = capped_mul(mag[k], cmag, 24, sat);
          if (fm > 64'h8000_0000_0000) begin
            fm  = 64'h8000_0000_0000;
            sat = 1'b1;
          end
          f = (neg[k] != cneg) ? -longint'(fm) : longint'(fm);
          f = clamp48(f, sat);
          acc[k] = clamp48(acc[k] + f, sat);
        end
        if (sat) sat_seen = 1'b1;
      end
    end
    if (p.last) begin
      r.fx  = acc[0][47:0];
      r.fy  = acc[1][47:0];
      r.fz  = acc[2][47:0];
      r.sat = sat_seen;
      expected_forces.insert(expected_forces.size(), r);
    end
  endfunction

  function automatic bit quiet_stretch();
    return accepted >= 300 && accepted < 420;
  endfunction

  // driver
  initial begin
    pair.valid = 1'b0;
    pair.disp_x = '0;
    pair.disp_y = '0;
    pair.disp_z = '0;
    pair.own_id = '0;
    pair.partner_id = '0;
    pair.first_pair = 1'b0;
    pair.last_pair = 1'b0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pair.valid <= 1'b0;
    end else begin
      if (pair.valid && pair.ready) begin
        accumulate_pair(cur_pair);
        accepted++;
      end
      if (!pair.valid || pair.ready) begin
        if (pending_pairs.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 24)) begin
          cur_pair = pending_pairs.pop_front();
          pair.valid      <= 1'b1;
          pair.disp_x     <= cur_pair.dx;
          pair.disp_y     <= cur_pair.dy;
          pair.disp_z     <= cur_pair.dz;
          pair.own_id     <= cur_pair.own;
          pair.partner_id <= cur_pair.partner;
          pair.first_pair <= cur_pair.first;
          pair.last_pair  <= cur_pair.last;
        end else begin
          pair.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  function automatic void check_field(input string name, input logic [47:0] exp_v,
                                      input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    force_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_forces.size() == 0) begin
          errors++;
          $display("%0t unexpected transfer: expected none actual %h %h %h %b", $time,
                   res.force_x, res.force_y, res.force_z, res.saturated);
        end else begin
          e = expected_forces.pop_front();
          check_field("force_x", e.fx, res.force_x);
          check_field("force_y", e.fy, res.force_y);
          check_field("force_z", e.fz, res.force_z);
          check_field("saturated", {47'b0, e.sat}, {47'b0, res.saturated});
        end
      end
      res.ready <= quiet_stretch() || $urandom_range(99) >= 24;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] index, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == ljfa_pkg::REG_COEF_ATTRACT) coef_a = value[31:0];
    else if (index == ljfa_pkg::REG_COEF_REPULSE) coef_b = value[31:0];
    else bias[index - ljfa_pkg::REG_BIAS_X] = longint'($signed(value[47:0]));
  endtask

  task automatic load_config(input logic [31:0] a, input logic [31:0] b,
                             input logic [47:0] bx, input logic [47:0] by,
                             input logic [47:0] bz);
    reg_write(ljfa_pkg::REG_COEF_ATTRACT, {32'b0, a});
    reg_write(ljfa_pkg::REG_COEF_REPULSE, {32'b0, b});
    reg_write(ljfa_pkg::REG_BIAS_X, {16'b0, bx});
    reg_write(ljfa_pkg::REG_BIAS_Y, {16'b0, by});
    reg_write(ljfa_pkg::REG_BIAS_Z, {16'b0, bz});
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || pair.valid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void push_pair(input logic [31:0] dx, input logic [31:0] dy,
                                    input logic [31:0] dz, input logic [IDW-1:0] own,
                                    input logic [IDW-1:0] partner, input logic first,
                                    input logic last);
    pair_t p;
    p.dx = dx;
    p.dy = dy;
    p.dz = dz;
    p.own = own;
    p.partner = partner;
    p.first = first;
    p.last = last;
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function automatic logic [31:0] rand_disp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    if (sel < 85) return $urandom();
    return $urandom_range(32'h2000) - 32'h1000;
  endfunction

  function automatic void push_sequences(input int n_items);
    int n, len;
    logic [IDW-1:0] own, partner;
    n = 0;
    while (n < n_items) begin
      len = $urandom_range(1, 6);
      own = IDW'($urandom());
      for (int i = 0; i < len; i++) begin
        partner = ($urandom_range(9) == 0) ? own : IDW'($urandom());
        if ($urandom_range(19) == 0) begin
          push_pair($urandom(), $urandom(), $urandom(), IDW'($urandom()),
                    IDW'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          push_pair(rand_disp(), rand_disp(), rand_disp(), own, partner,
                    i == 0 && $urandom_range(9) != 0,
                    i == len - 1 && $urandom_range(9) != 0);
        end
        n++;
      end
    end
  endfunction

  initial begin
    coef_a = 32'd1572864;
    coef_b = 32'd3145728;
    for (int k = 0; k < 3; k++) begin
      bias[k] = 0;
      acc[k] = 0;
    end
    sat_seen = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed pairs under reset settings
    push_pair($urandom(), $urandom(), $urandom(), 20'h12345, 20'h12345, 1, 1);
    push_pair(32'h0100_0000, 0, 0, 0, 20'hFFFFF, 1, 1);
    push_pair(0, 32'h0100_0000, 0, 20'hFFFFF, 0, 1, 1);
    push_pair(0, 0, 0, 1, 2, 1, 1);
    push_pair(32'h0000_1000, 0, 0, 3, 4, 1, 1);
    push_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5, 6, 1, 1);
    push_pair(32'hFF00_0000, 32'h0080_0000, 32'hFFC0_0000, 7, 8, 0, 1);
    push_pair(32'h0120_0000, 32'hFF10_0000, 32'h0005_0000, 9, 10, 1, 0);
    push_pair(32'hFEE0_0000, 32'h0033_0000, 32'h0100_0000, 9, 11, 0, 0);
    push_pair(32'h0000_0001, 32'hFFFF_FFFF, 0, 9, 12, 0, 0);
    push_pair(32'h00E0_0000, 32'h00E0_0000, 32'h00E0_0000, 9, 9, 0, 1);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hAAAAA, 20'h55555, 1, 1);
    push_pair(32'h0180_0000, 0, 0, 1, 0, 0, 0);
    push_pair(32'h0200_0000, 32'hFE00_0000, 0, 1, 0, 0, 1);
    push_sequences(60);
    drain();

    load_config(32'd0, 32'd0, 48'h8000_0000_0000, 48'h8000_0000_0000,
                48'h8000_0000_0000);
    push_pair(32'h0100_0000, 32'hFF00_0000, 0, 1, 2, 1, 1);
    push_sequences(100);
    drain();

    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                48'h7FFF_FFFF_FFFF);
    push_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1, 2, 1, 1);
    push_pair(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 1, 2, 1, 1);
    push_sequences(100);
    drain();

    load_config(32'hFFFF_FFFF, 32'd0, 48'h0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    push_sequences(100);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      load_config($urandom_range(32'h00FF_FFFF), $urandom_range(32'h00FF_FFFF),
                  48'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000),
                  48'($signed($urandom())), 48'({$urandom(), $urandom()}));
      push_sequences(110);
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ljfa_pkg.sv
design/ljfa_if.sv
design/ljfa_mul.sv
design/ljfa_div.sv
design/lennard_jones_force_accumulator.sv
test/tb_top.sv
